FILE: rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_FIND       = 3'd4,
    KIND_READ_POS   = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: rtl/double_ended_queue_with_search.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of 64 signed 32-bit values with linear search.
// Input channel in_*: one item per operation. in_tuser carries the operation
// (push front, push back, pop front, pop back, find value, read position);
// in_tdata carries the value and the 1-based position.
// Result channel out_*: exactly one item per input item, in order. out_tuser
// carries the status (ok, not found or empty, full); out_tdata carries the
// value read and the 1-based position of the first match.
// Items are worked on one at a time; in_tready is high only between items.
// Pushes, pops, unused kinds, finds on an empty queue and reads out of range
// go from acceptance straight to the result state; a position read in range
// passes through memory address, registered read and result states.
// A find walks the stored entries one per cycle through the single memory
// read port and one comparator, and stops early at the first match.
// The next item is accepted only once the previous result has moved to
// the output register. The result sits in an output register;
// the next item is accepted while it waits, but its own result is held until
// the receiver takes the previous. Reset empties the queue (head and count to
// zero); no clearing pass is run.
module double_ended_queue_with_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value [31:0], position [39:32]
  input  logic [2:0]  in_tuser,   // kind [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value [31:0], result_position [38:32], zero [39]
  output logic [1:0]  out_tuser   // status [1:0]
);

  dq_pkg::mem_req_t          mem_req;
  logic [dq_pkg::DATA_W-1:0] mem_rdata;
  dq_pkg::status_t           out_status;
  logic [dq_pkg::DATA_W-1:0] out_value;
  logic [dq_pkg::CNT_W-1:0]  out_pos;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_tvalid),
    .in_rdy     (in_tready),
    .in_kind    (dq_pkg::kind_t'(in_tuser)),
    .in_value   (in_tdata[31:0]),
    .in_pos     (in_tdata[39:32]),
    .out_vld    (out_tvalid),
    .out_rdy    (out_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_pos    (out_pos),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  dq_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign out_tdata = {1'b0, out_pos, out_value};
  assign out_tuser = out_status;

endmodule

FILE: rtl/dq_mem.sv
`timescale 1ns / 1ps

module dq_mem (
  input  logic                      clk,
  input  dq_pkg::mem_req_t          req,
  output logic [dq_pkg::DATA_W-1:0] rdata
);

  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  output logic                      in_rdy,
  input  dq_pkg::kind_t             in_kind,
  input  logic [dq_pkg::DATA_W-1:0] in_value,
  input  logic [dq_pkg::POS_W-1:0]  in_pos,
  output logic                      out_vld,
  input  logic                      out_rdy,
  output dq_pkg::status_t           out_status,
  output logic [dq_pkg::DATA_W-1:0] out_value,
  output logic [dq_pkg::CNT_W-1:0]  out_pos,
  output dq_pkg::mem_req_t          mem_req,
  input  logic [dq_pkg::DATA_W-1:0] mem_rdata
);

  dq_pkg::state_t            state_r, state_nxt;
  logic [dq_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [dq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [dq_pkg::CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [dq_pkg::CNT_W-1:0]  cmp_pos_r, cmp_pos_nxt;
  logic [dq_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [dq_pkg::POS_W-1:0]  pos_r, pos_nxt;
  dq_pkg::status_t           res_status_r, res_status_nxt;
  logic [dq_pkg::DATA_W-1:0] res_val_r, res_val_nxt;
  logic [dq_pkg::CNT_W-1:0]  res_pos_r, res_pos_nxt;
  logic                      out_vld_r, out_vld_nxt;
  dq_pkg::status_t           out_status_r;
  logic [dq_pkg::DATA_W-1:0] out_val_r;
  logic [dq_pkg::CNT_W-1:0]  out_pos_r;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      pos_ok;
  logic                      issue;
  logic                      hit;
  logic                      slot_free;
  logic                      is_push;
  logic [dq_pkg::PTR_W-1:0]  offset;
  logic [dq_pkg::PTR_W-1:0]  slot;

  assign in_rdy    = (state_r == dq_pkg::ST_IDLE);
  assign accept    = in_vld && in_rdy;
  assign full      = (count_r == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign pos_ok    = (in_pos != '0) && (in_pos <= dq_pkg::POS_W'(count_r));
  assign issue     = (scan_idx_r < count_r);
  assign hit       = cmp_vld_r && (mem_rdata == value_r);
  assign slot_free = !out_vld_r || out_rdy;
  assign is_push   = (in_kind == dq_pkg::KIND_PUSH_FRONT) ||
                     (in_kind == dq_pkg::KIND_PUSH_BACK);

  // Shared address unit: every memory access goes through head + offset
  always_comb begin
    unique case (state_r)
      dq_pkg::ST_IDLE:    offset = (in_kind == dq_pkg::KIND_PUSH_FRONT) ?
                                   '1 : count_r[dq_pkg::PTR_W-1:0];
      dq_pkg::ST_SCAN:    offset = scan_idx_r[dq_pkg::PTR_W-1:0];
      dq_pkg::ST_RD_ADDR: offset = dq_pkg::PTR_W'(pos_r - dq_pkg::POS_W'(1));
      default:            offset = '0;
    endcase
  end

  assign slot = head_r + offset;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_kind == dq_pkg::KIND_FIND && !empty) begin
            state_nxt = dq_pkg::ST_SCAN;
          end else if (in_kind == dq_pkg::KIND_READ_POS && pos_ok) begin
            state_nxt = dq_pkg::ST_RD_ADDR;
          end else begin
            state_nxt = dq_pkg::ST_RESP;
          end
        end
      end
      dq_pkg::ST_SCAN: begin
        if (hit || !issue) begin
          state_nxt = dq_pkg::ST_RESP;
        end
      end
      dq_pkg::ST_RD_ADDR: state_nxt = dq_pkg::ST_RD_DATA;
      dq_pkg::ST_RD_DATA: state_nxt = dq_pkg::ST_RESP;
      dq_pkg::ST_RESP: begin
        if (slot_free) begin
          state_nxt = dq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_req.we    = accept && is_push && !full;
    mem_req.waddr = slot;
    mem_req.wdata = in_value;
    mem_req.raddr = slot;
  end

  // Datapath next values
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_pos_nxt    = cmp_pos_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_pos_nxt    = res_pos_r;
    out_vld_nxt    = out_vld_r && !out_rdy;

    unique case (state_r)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          value_nxt      = in_value;
          pos_nxt        = in_pos;
          scan_idx_nxt   = '0;
          cmp_vld_nxt    = 1'b0;
          res_status_nxt = dq_pkg::STAT_OK;
          res_val_nxt    = '0;
          res_pos_nxt    = '0;
          unique case (in_kind)
            dq_pkg::KIND_PUSH_FRONT: begin
              if (full) begin
                res_status_nxt = dq_pkg::STAT_FULL;
              end else begin
                head_nxt  = slot;
                count_nxt = count_r + dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::KIND_PUSH_BACK: begin
              if (full) begin
                res_status_nxt = dq_pkg::STAT_FULL;
              end else begin
                count_nxt = count_r + dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::KIND_POP_FRONT: begin
              if (empty) begin
                res_status_nxt = dq_pkg::STAT_MISS;
              end else begin
                head_nxt  = head_r + dq_pkg::PTR_W'(1);
                count_nxt = count_r - dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::KIND_POP_BACK: begin
              if (empty) begin
                res_status_nxt = dq_pkg::STAT_MISS;
              end else begin
                count_nxt = count_r - dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::KIND_FIND: begin
              if (empty) begin
                res_status_nxt = dq_pkg::STAT_MISS;
              end
            end
            dq_pkg::KIND_READ_POS: begin
              if (!pos_ok) begin
                res_status_nxt = dq_pkg::STAT_MISS;
              end
            end
            default: ;
          endcase
        end
      end
      dq_pkg::ST_SCAN: begin
        // Issue one read a cycle and compare the entry fetched the cycle before
        if (issue) begin
          scan_idx_nxt = scan_idx_r + dq_pkg::CNT_W'(1);
        end
        cmp_vld_nxt = issue;
        cmp_pos_nxt = scan_idx_r + dq_pkg::CNT_W'(1);
        if (hit) begin
          res_status_nxt = dq_pkg::STAT_OK;
          res_pos_nxt    = cmp_pos_r;
        end else if (!issue) begin
          res_status_nxt = dq_pkg::STAT_MISS;
        end
      end
      dq_pkg::ST_RD_DATA: res_val_nxt = mem_rdata;
      dq_pkg::ST_RESP: begin
        if (slot_free) begin
          out_vld_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dq_pkg::ST_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    cmp_pos_r    <= cmp_pos_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_pos_r    <= res_pos_nxt;
    if (state_r == dq_pkg::ST_RESP && slot_free) begin
      out_status_r <= res_status_r;
      out_val_r    <= res_val_r;
      out_pos_r    <= res_pos_r;
    end
  end

  assign out_vld    = out_vld_r;
  assign out_status = out_status_r;
  assign out_value  = out_val_r;
  assign out_pos    = out_pos_r;

endmodule

FILE: rtl/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Hold a stalled result item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  // One item at a time: ready drops after an item is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // A match position comes only with ok status and no read value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38:32] != 7'd0 |->
      out_tuser == dq_pkg::STAT_OK && out_tdata[31:0] == 32'd0)
    else $error("match position with wrong status or value");

  // Status code within range, padding bit clear
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3 && out_tdata[39] == 1'b0)
    else $error("bad status code or padding");

  // A result never appears while the block still waits for an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !out_tvalid |=> !out_tvalid || !$past(in_tready) || $past(in_tvalid))
    else $error("result without an accepted item");

endmodule

bind double_ended_queue_with_search dq_checker u_dq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
